// ===== rtl/core/arv3_pkg.sv =====
package arv3_pkg;

  // Default sizes of the datapath.
  localparam int COORD_WIDTH_DEF   = 16;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 18;

  // Fraction bits carried through the rotator.
  localparam int FRAC_BITS = 28;

  // Fraction bits of the inverse gain constant.
  localparam int GAIN_FRAC = 30;

  // Inverse CORDIC gain 0.6072529350 in Q30, truncated.
  localparam logic [GAIN_FRAC-1:0] INV_GAIN = 30'd652032874;

  // Rotation axis codes. The fourth code rotates nothing.
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Quarter turn that is applied exactly ahead of the micro-rotations.
  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  // atan(2^-i) with 2^32 units per full turn.
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

endpackage

// ===== rtl/core/arv3_in_if.sv =====
interface arv3_in_if #(
  parameter int COORD_WIDTH = arv3_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = arv3_pkg::ANGLE_WIDTH_DEF
);

  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] in_z;
  logic [ANGLE_WIDTH-1:0]        angle;

  modport source (
    output valid, func, in_x, in_y, in_z, angle,
    input  ready
  );

  modport sink (
    input  valid, func, in_x, in_y, in_z, angle,
    output ready
  );

endinterface

// ===== rtl/core/arv3_out_if.sv =====
interface arv3_out_if #(
  parameter int COORD_WIDTH = arv3_pkg::COORD_WIDTH_DEF
);

  logic                        valid;
  logic                        ready;
  logic signed [COORD_WIDTH:0] out_x;
  logic signed [COORD_WIDTH:0] out_y;
  logic signed [COORD_WIDTH:0] out_z;

  modport source (
    output valid, out_x, out_y, out_z,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z,
    output ready
  );

endinterface

// ===== rtl/core/axis_rotate_vector3.sv =====
// Pipeline stages from an accepted beat to its result, in order:
// one gain multiply stage, one quarter-turn stage, one stage per micro-rotation, one rounding stage.
// Throughput: one beat per cycle unless result.ready holds the output; every stage holds one item
// and a stalled stage lets the stages behind it fill their empty slots.
// Reset (synchronous, active high) clears every valid bit; data registers are not reset.
module axis_rotate_vector3 #(
  parameter int COORD_WIDTH   = arv3_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = arv3_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = arv3_pkg::CORDIC_STAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  arv3_in_if.sink    item,
  arv3_out_if.source result
);

  localparam int CW = COORD_WIDTH;
  localparam int OW = COORD_WIDTH + 1;
  localparam int DW = COORD_WIDTH + arv3_pkg::FRAC_BITS + 2;
  localparam int PW = COORD_WIDTH + arv3_pkg::GAIN_FRAC + 1;
  localparam int N  = CORDIC_STAGES;

  localparam logic signed [DW-1:0] HALF_LSB = DW'(1) <<< (arv3_pkg::FRAC_BITS - 1);
  localparam logic signed [arv3_pkg::GAIN_FRAC:0] GAIN_S = {1'b0, arv3_pkg::INV_GAIN};

  // Operand selection, angle reduction and gain multiply.
  logic signed [CW-1:0] sel_a;
  logic signed [CW-1:0] sel_b;
  logic signed [CW-1:0] sel_c;
  logic                 sel_byp;
  logic [31:0]          ang32;
  logic [31:0]          ang_off;
  logic [1:0]           quad;
  logic [31:0]          resid;
  logic signed [PW-1:0] prod_a;
  logic signed [PW-1:0] prod_b;

  always_comb begin
    sel_byp = 1'b0;
    case (arv3_pkg::axis_t'(item.func))
      arv3_pkg::AXIS_X: begin
        sel_a = item.in_y;
        sel_b = item.in_z;
        sel_c = item.in_x;
      end
      arv3_pkg::AXIS_Y: begin
        sel_a = item.in_z;
        sel_b = item.in_x;
        sel_c = item.in_y;
      end
      arv3_pkg::AXIS_Z: begin
        sel_a = item.in_x;
        sel_b = item.in_y;
        sel_c = item.in_z;
      end
      default: begin
        sel_a   = item.in_y;
        sel_b   = item.in_z;
        sel_c   = item.in_x;
        sel_byp = 1'b1;
      end
    endcase
  end

  always_comb begin
    ang32   = 32'(item.angle) << (32 - ANGLE_WIDTH);
    ang_off = ang32 + 32'h2000_0000;
    quad    = sel_byp ? arv3_pkg::QUAD_0 : ang_off[31:30];
    resid   = ang32 - {quad, 30'd0};
  end

  // An item with no axis skips the gain so its coordinates come back unchanged.
  always_comb begin
    if (sel_byp) begin
      prod_a = PW'($signed({sel_a, {arv3_pkg::GAIN_FRAC{1'b0}}}));
      prod_b = PW'($signed({sel_b, {arv3_pkg::GAIN_FRAC{1'b0}}}));
    end else begin
      prod_a = sel_a * GAIN_S;
      prod_b = sel_b * GAIN_S;
    end
  end

  // Stage enables: a stage loads when it is empty or its content moves on.
  logic         m_en;
  logic [N:0]   en;
  logic         o_en;
  logic         m_v;
  logic [N:0]   v;
  logic         o_v;

  assign o_en = !o_v || result.ready;
  assign en[N] = !v[N] || o_en;

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_en
      assign en[k] = !v[k] || en[k+1];
    end
  endgenerate

  assign m_en       = !m_v || en[0];
  assign item.ready = m_en;

  // Multiply stage registers.
  logic signed [PW-1:0] m_pa;
  logic signed [PW-1:0] m_pb;
  logic signed [CW-1:0] m_c;
  logic [1:0]           m_quad;
  logic [31:0]          m_res;
  logic [1:0]           m_func;
  logic                 m_byp;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (m_en) begin
      m_v <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_en) begin
      m_pa   <= prod_a;
      m_pb   <= prod_b;
      m_c    <= sel_c;
      m_quad <= quad;
      m_res  <= resid;
      m_func <= item.func;
      m_byp  <= sel_byp;
    end
  end

  // Rotator stage registers; index 0 holds the quarter-turn result.
  logic signed [DW-1:0] a_q [N+1];
  logic signed [DW-1:0] b_q [N+1];
  logic signed [31:0]   z_q [N+1];
  logic signed [CW-1:0] c_q [N+1];
  logic [1:0]           f_q [N+1];
  logic                 byp_q [N+1];

  // Quarter turn: exact swap and negation of the scaled pair.
  logic signed [DW-1:0] sa;
  logic signed [DW-1:0] sb;
  logic signed [DW-1:0] a0_next;
  logic signed [DW-1:0] b0_next;

  always_comb begin
    sa = DW'(m_pa >>> (arv3_pkg::GAIN_FRAC - arv3_pkg::FRAC_BITS));
    sb = DW'(m_pb >>> (arv3_pkg::GAIN_FRAC - arv3_pkg::FRAC_BITS));
    case (arv3_pkg::quad_t'(m_quad))
      arv3_pkg::QUAD_0: begin
        a0_next = sa;
        b0_next = sb;
      end
      arv3_pkg::QUAD_90: begin
        a0_next = -sb;
        b0_next = sa;
      end
      arv3_pkg::QUAD_180: begin
        a0_next = -sa;
        b0_next = -sb;
      end
      default: begin
        a0_next = sb;
        b0_next = -sa;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_q[0]   <= a0_next;
      b_q[0]   <= b0_next;
      z_q[0]   <= $signed(m_res);
      c_q[0]   <= m_c;
      f_q[0]   <= m_func;
      byp_q[0] <= m_byp;
    end
  end

  // One micro-rotation per stage, steered by the sign of the residual angle.
  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_rot
      logic signed [DW-1:0] da;
      logic signed [DW-1:0] db;
      logic signed [31:0]   step;
      logic signed [DW-1:0] a_next;
      logic signed [DW-1:0] b_next;
      logic signed [31:0]   z_next;

      always_comb begin
        da   = b_q[i] >>> i;
        db   = a_q[i] >>> i;
        step = $signed(arv3_pkg::ATAN_TAB[i]);
        if (byp_q[i]) begin
          a_next = a_q[i];
          b_next = b_q[i];
          z_next = z_q[i];
        end else if (!z_q[i][31]) begin
          a_next = a_q[i] - da;
          b_next = b_q[i] + db;
          z_next = z_q[i] - step;
        end else begin
          a_next = a_q[i] + da;
          b_next = b_q[i] - db;
          z_next = z_q[i] + step;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[i+1] <= 1'b0;
        end else if (en[i+1]) begin
          v[i+1] <= v[i];
        end
      end

      always_ff @(posedge clk) begin
        if (en[i+1]) begin
          a_q[i+1]   <= a_next;
          b_q[i+1]   <= b_next;
          z_q[i+1]   <= z_next;
          c_q[i+1]   <= c_q[i];
          f_q[i+1]   <= f_q[i];
          byp_q[i+1] <= byp_q[i];
        end
      end
    end
  endgenerate

  // Round to nearest, ties upward, and put the pair back on its axes.
  logic signed [DW-1:0] sum_a;
  logic signed [DW-1:0] sum_b;
  logic signed [OW-1:0] rnd_a;
  logic signed [OW-1:0] rnd_b;
  logic signed [OW-1:0] pass_c;
  logic signed [OW-1:0] x_next;
  logic signed [OW-1:0] y_next;
  logic signed [OW-1:0] z_next;

  always_comb begin
    sum_a  = a_q[N] + HALF_LSB;
    sum_b  = b_q[N] + HALF_LSB;
    rnd_a  = OW'(sum_a >>> arv3_pkg::FRAC_BITS);
    rnd_b  = OW'(sum_b >>> arv3_pkg::FRAC_BITS);
    pass_c = OW'(c_q[N]);
    case (arv3_pkg::axis_t'(f_q[N]))
      arv3_pkg::AXIS_Y: begin
        x_next = rnd_b;
        y_next = pass_c;
        z_next = rnd_a;
      end
      arv3_pkg::AXIS_Z: begin
        x_next = rnd_a;
        y_next = rnd_b;
        z_next = pass_c;
      end
      default: begin
        x_next = pass_c;
        y_next = rnd_a;
        z_next = rnd_b;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (o_en) begin
      o_v <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      result.out_x <= x_next;
      result.out_y <= y_next;
      result.out_z <= z_next;
    end
  end

  assign result.valid = o_v;

  // An accepted beat always lands in the multiply stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> m_v)
    else $error("accepted beat did not enter the multiply stage");

  // Input back-pressure only when every stage holds an item.
  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> m_v && (&v) && o_v)
    else $error("input stalled while a stage was empty");

  // A stalled multiply stage keeps its item.
  a_mult_holds: assert property (@(posedge clk) disable iff (rst)
    m_v && !en[0] |=> m_v && $stable(m_pa) && $stable(m_pb))
    else $error("multiply stage lost its item during a stall");

endmodule
